// ----- rtl/core/cpd_pkg.sv -----
package cpd_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE = 8'd2;
  localparam logic [7:0] STOP_BYTE  = 8'd3;

  // Crc polynomial after reset
  localparam logic [15:0] CRC_POLY_RESET = 16'h1021;

  // Result event codes
  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_GOOD     = 2'd1,
    EV_CRC_BAD  = 2'd2,
    EV_STOP_BAD = 2'd3
  } event_t;

  // Deframer phase, one-hot
  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_CRC_HI  = 6'b001000,
    PH_CRC_LO  = 6'b010000,
    PH_STOP    = 6'b100000
  } phase_t;

endpackage

// ----- rtl/core/crc_checked_packet_deframer.sv -----
// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall  in_rx_byte
// out_     out  out_valid/out_stall out_event_res, out_data_byte, out_byte_position,
//                                   out_frame_length
// cfg_     in   cfg_valid/cfg_ready cfg_crc_poly
//
// One byte per cycle while the result register is free or being taken: a byte is held in
// the input register, then the phase machine and byte-wide crc fold decide it and load the
// result register when the byte yields a result.
// Synchronous active-low reset returns to the start-byte hunt with polynomial 0x1021.
// out_stall holds the result register; the input register keeps taking requests while
// the result register is free or is being taken.
module crc_checked_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_byte_position,
  output logic [7:0]  out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_crc_poly
);
  import cpd_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic [15:0] poly_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  taken_r, taken_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [15:0] crc_fold;
  logic [7:0]  taken_inc;
  logic        adv;
  logic        emit;
  event_t      ev;
  logic        out_vld_r, out_vld_nxt;
  event_t      out_ev_r;
  logic [7:0]  out_data_r;
  logic [7:0]  out_pos_r;
  logic [7:0]  out_len_r;

  assign cfg_ready = 1'b1;

  // Advance the held byte when the result register is free or being drained
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  assign in_vld_nxt = (in_valid && !in_stall) ? 1'b1 : (adv ? 1'b0 : in_vld_r);

  cpd_crc_fold u_fold (
    .crc_in  (crc_r),
    .data_in (in_byte_r),
    .poly    (poly_r),
    .crc_out (crc_fold)
  );

  assign taken_inc = taken_r + 8'd1;

  // Phase machine
  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    taken_nxt  = taken_r;
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    emit       = 1'b0;
    ev         = EV_DATA;
    case (phase_r)
      PH_HUNT: begin
        if (in_byte_r == START_BYTE) phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (in_byte_r == 8'd0) begin
          phase_nxt = PH_HUNT;
        end else begin
          len_nxt   = in_byte_r;
          taken_nxt = 8'd0;
          crc_nxt   = 16'd0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit      = 1'b1;
        ev        = EV_DATA;
        crc_nxt   = crc_fold;
        taken_nxt = taken_inc;
        if (taken_inc >= len_r) phase_nxt = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_hi_nxt = in_byte_r;
        phase_nxt  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({crc_hi_r, in_byte_r} != crc_r) begin
          emit      = 1'b1;
          ev        = EV_CRC_BAD;
          phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_STOP;
        end
      end
      PH_STOP: begin
        emit      = 1'b1;
        ev        = (in_byte_r == STOP_BYTE) ? EV_GOOD : EV_STOP_BAD;
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  assign out_vld_nxt = adv ? emit : (out_stall ? out_vld_r : 1'b0);

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      poly_r    <= CRC_POLY_RESET;
      phase_r   <= PH_HUNT;
      len_r     <= 8'd0;
      taken_r   <= 8'd0;
      crc_r     <= 16'd0;
      crc_hi_r  <= 8'd0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) poly_r <= cfg_crc_poly;
      if (adv) begin
        phase_r  <= phase_nxt;
        len_r    <= len_nxt;
        taken_r  <= taken_nxt;
        crc_r    <= crc_nxt;
        crc_hi_r <= crc_hi_nxt;
      end
    end
  end

  // Capture the input request and load the result register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte_r <= in_rx_byte;
    if (adv && emit) begin
      out_ev_r   <= ev;
      out_data_r <= (ev == EV_DATA) ? in_byte_r : 8'd0;
      out_pos_r  <= (ev == EV_DATA) ? taken_r : 8'd0;
      out_len_r  <= len_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_res     = out_ev_r;
  assign out_data_byte     = out_data_r;
  assign out_byte_position = out_pos_r;
  assign out_frame_length  = out_len_r;

  // Payload count never reaches the announced length while in the payload phase
  a_taken_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (taken_r < len_r))
    else $error("payload count reached announced length");

  // A payload byte always yields a data result
  a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && phase_r == PH_PAYLOAD) |=> (out_vld_r && out_ev_r == EV_DATA))
    else $error("payload byte produced no data result");

  // Non-data results carry zero data and position
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ev_r != EV_DATA) |-> (out_data_r == 8'd0 && out_pos_r == 8'd0))
    else $error("status result carries payload fields");

  // Stall the input only while a byte is held
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

endmodule

// ----- rtl/core/cpd_crc_fold.sv -----
module cpd_crc_fold (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  input  logic [15:0] poly,
  output logic [15:0] crc_out
);

  // Fold one byte into the crc, msb first, one bit per step
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import cpd_pkg::*;

  // Expected deframer output for one request
  typedef struct {
    event_t     ev;
    logic [7:0] data;
    logic [7:0] pos;
    logic [7:0] len;
  } deframe_result_t;

  // How a generated frame is broken, if at all
  typedef enum int {
    FRAME_OK,
    FRAME_BAD_CRC,
    FRAME_BAD_STOP
  } frame_fault_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_res;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_byte_position;
  logic [7:0]  out_frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_crc_poly = CRC_POLY_RESET;

  // Stimulus and scoreboard
  logic [7:0]      rx_stream[$];
  deframe_result_t pending_events[$];
  int unsigned     bytes_queued = 0;
  int unsigned     bytes_accepted = 0;
  int unsigned     noise_bytes = 0;
  int unsigned     mismatches = 0;
  int unsigned     idle_pct = 23;
  logic            in_taken = 1'b0;

  // Deframer state mirror
  logic [15:0] crc_poly_now = CRC_POLY_RESET;
  phase_t      rx_phase = PH_HUNT;
  logic [7:0]  rx_len = 8'd0;
  logic [7:0]  rx_taken = 8'd0;
  logic [15:0] rx_crc = 16'd0;
  logic [7:0]  rx_crc_hi = 8'd0;
  logic [15:0] frame_crc = 16'd0;

  crc_checked_packet_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_data_byte     (out_data_byte),
    .out_byte_position (out_byte_position),
    .out_frame_length  (out_frame_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_crc_poly      (cfg_crc_poly)
  );

  always #2 clk = ~clk;

  // Fold one byte into an MSB-first CRC-16
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Advance the deframer mirror by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] fcs;
    case (rx_phase)
      PH_HUNT: begin
        if (b == START_BYTE) rx_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          rx_phase = PH_HUNT;
        end else begin
          rx_len = b;
          rx_taken = 8'd0;
          rx_crc = 16'd0;
          rx_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pending_events.push_back('{EV_DATA, b, rx_taken, rx_len});
        rx_crc = crc16_byte(rx_crc, b, crc_poly_now);
        rx_taken = rx_taken + 8'd1;
        if (rx_taken >= rx_len) rx_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rx_crc_hi = b;
        rx_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        fcs = {rx_crc_hi, b};
        if (fcs != rx_crc) begin
          rx_phase = PH_HUNT;
          pending_events.push_back('{EV_CRC_BAD, 8'd0, 8'd0, rx_len});
        end else begin
          rx_phase = PH_STOP;
        end
      end
      PH_STOP: begin
        rx_phase = PH_HUNT;
        pending_events.push_back('{(b == STOP_BYTE) ? EV_GOOD : EV_STOP_BAD,
                                   8'd0, 8'd0, rx_len});
      end
      default: begin
        rx_phase = PH_HUNT;
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_payload(input logic [7:0] b);
    push_byte(b);
    frame_crc = crc16_byte(frame_crc, b, crc_poly_now);
  endtask

  task automatic push_noise(input logic [7:0] b);
    push_byte(b);
    noise_bytes++;
  endtask

  // Queue a whole frame with random payload
  task automatic queue_frame(input int unsigned len, input frame_fault_t fault);
    logic [15:0] fcs;
    logic [7:0]  stop;
    push_byte(START_BYTE);
    push_byte(8'(len));
    frame_crc = 16'd0;
    repeat (len) push_payload(8'($urandom_range(255)));
    fcs = frame_crc;
    if (fault == FRAME_BAD_CRC) fcs = fcs ^ 16'($urandom_range(65535, 1));
    push_byte(fcs[15:8]);
    push_byte(fcs[7:0]);
    if (fault != FRAME_BAD_CRC) begin
      stop = STOP_BYTE;
      if (fault == FRAME_BAD_STOP) begin
        stop = 8'($urandom_range(254));
        if (stop >= STOP_BYTE) stop = stop + 8'd1;
      end
      push_byte(stop);
    end
  endtask

  // Wait until every request is taken and every result checked, then let the pipe empty
  task automatic drain();
    while (bytes_accepted != bytes_queued || pending_events.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_poly(input logic [15:0] poly);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_crc_poly <= poly;
    do @(posedge clk); while (!cfg_ready);
    crc_poly_now = poly;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drive requests at the falling edge; hold a request until it is taken
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Check results and predict from accepted requests at the rising edge
  always @(posedge clk) begin
    deframe_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          report_mismatch("result with none pending, event", out_event_res, 0);
        end else begin
          want = pending_events.pop_front();
          if (out_event_res !== want.ev)
            report_mismatch("event", out_event_res, want.ev);
          if (out_data_byte !== want.data)
            report_mismatch("data byte", out_data_byte, want.data);
          if (out_byte_position !== want.pos)
            report_mismatch("byte position", out_byte_position, want.pos);
          if (out_frame_length !== want.len)
            report_mismatch("frame length", out_frame_length, want.len);
        end
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
        bytes_accepted++;
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  initial begin
    logic [15:0] phase_polys[5];
    int unsigned start_count;
    int unsigned kind;
    logic [7:0]  nb;

    phase_polys = '{16'hFFFF, 16'h0000, 16'h8005, 16'($urandom_range(65535)), CRC_POLY_RESET};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ignored bytes while hunting, zero length, good, bad crc, bad stop
    push_noise(8'hFF);
    push_noise(8'h00);
    push_noise(STOP_BYTE);
    push_byte(START_BYTE);
    push_byte(8'd0);
    queue_frame(1, FRAME_OK);
    queue_frame(1, FRAME_BAD_CRC);
    queue_frame(2, FRAME_BAD_STOP);

    // Split a frame across a polynomial change
    push_byte(START_BYTE);
    push_byte(8'd3);
    frame_crc = 16'd0;
    push_payload(8'($urandom_range(255)));
    push_payload(8'($urandom_range(255)));
    drain();
    write_poly(phase_polys[0]);
    push_payload(8'($urandom_range(255)));
    push_byte(frame_crc[15:8]);
    push_byte(frame_crc[7:0]);
    push_byte(STOP_BYTE);

    // Random frames, one polynomial per phase, no idling in the middle phase
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_poly(phase_polys[ph]);
      idle_pct = (ph == 2) ? 0 : 23;
      start_count = bytes_queued - noise_bytes;
      if (ph == 1 || ph == 3) queue_frame(255, FRAME_OK);
      while (bytes_queued - noise_bytes - start_count < 390) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          queue_frame(($urandom_range(19) == 0) ? $urandom_range(255, 13)
                                                : $urandom_range(12, 1), FRAME_OK);
        end else if (kind < 80) begin
          queue_frame($urandom_range(12, 1), FRAME_BAD_CRC);
        end else if (kind < 88) begin
          queue_frame($urandom_range(12, 1), FRAME_BAD_STOP);
        end else if (kind < 93) begin
          push_byte(START_BYTE);
          push_byte(8'd0);
        end else begin
          // Line noise, now and then a stray start byte
          repeat ($urandom_range(4, 1)) begin
            nb = 8'($urandom_range(255));
            if (nb == START_BYTE && $urandom_range(3) != 0) nb = 8'hA5;
            push_noise(nb);
          end
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- crc_checked_packet_deframer.f -----
rtl/core/cpd_pkg.sv
rtl/core/cpd_crc_fold.sv
rtl/core/crc_checked_packet_deframer.sv
tb/tb.sv
